>>> rtl/i2a_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII radix converter.
// No dependencies; imported by i2a_ctrl, i2a_dp and integer_to_ascii_radix_unit.
package i2a_pkg;

    // Fixed field widths of the two channels and of one stored digit
    localparam int NUMBER_W = 32;
    localparam int BASE_W   = 5;
    localparam int PAD_W    = 6;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIGITS = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Quotient bits resolved per cycle by the divide unit
    localparam int STEP_BITS = 8;

    // ASCII codes and radix limits
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A       = 7'h61;
    localparam logic [BASE_W-1:0] DECIMAL_BASE = 5'd10;
    localparam logic [BASE_W-1:0] RADIX_MIN    = 5'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX    = 5'd16;

    // Output character source
    typedef logic [1:0] out_sel_t;
    localparam out_sel_t OSEL_SIGN  = 2'd0;
    localparam out_sel_t OSEL_FILL  = 2'd1;
    localparam out_sel_t OSEL_DIGIT = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     emit_start;
        logic     out_load;
        out_sel_t out_sel;
    } i2a_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic conv_last;
        logic sign_first;
        logic fill_none;
        logic k_one;
        logic out_free;
    } i2a_stat_t;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < 4'd10) begin
            return CHAR_ZERO + d_ext;
        end
        return CHAR_A + d_ext - 7'd10;
    endfunction

endpackage

>>> rtl/i2a_ctrl.sv
// Sequencer for the radix converter: divide passes, then sign, fill and digits.
// Depends on i2a_pkg; drives i2a_dp through i2a_cmd_t.
module i2a_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2a_pkg::i2a_stat_t  stat,
    output i2a_pkg::i2a_cmd_t   cmd
);
    import i2a_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV     = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_SIGN    = 3'd3;
    localparam logic [2:0] ST_FILL    = 3'd4;
    localparam logic [2:0] ST_DIG_RD  = 3'd5;
    localparam logic [2:0] ST_DIG_PUT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.out_sel = OSEL_DIGIT;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.conv_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.emit_start = 1'b1;
                state_next     = stat.sign_first ? ST_SIGN : ST_FILL;
            end
            ST_SIGN: begin
                cmd.out_sel = OSEL_SIGN;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.out_sel = OSEL_FILL;
                if (stat.fill_none) begin
                    state_next = ST_DIG_RD;
                end else if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                end
            end
            ST_DIG_RD: begin
                // let the store read settle for the current digit index
                state_next = ST_DIG_PUT;
            end
            ST_DIG_PUT: begin
                cmd.out_sel = OSEL_DIGIT;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.k_one ? ST_IDLE : ST_DIG_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/i2a_dp.sv
// Datapath of the radix converter: shared divide unit, digit store, output register.
// Depends on i2a_pkg; commanded by i2a_ctrl.
module i2a_dp #(
    parameter int MAX_DIGITS = i2a_pkg::DEF_MAX_DIGITS,
    parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [i2a_pkg::NUMBER_W-1:0]   s_number,
    input  logic        [i2a_pkg::BASE_W-1:0]     s_base,
    input  logic        [i2a_pkg::PAD_W-1:0]      s_min_digits,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [i2a_pkg::CHAR_W-1:0]     m_out_char,
    output logic                                  m_last_char,
    input  i2a_pkg::i2a_cmd_t                     cmd,
    output i2a_pkg::i2a_stat_t                    stat
);
    import i2a_pkg::*;

    localparam int PASSES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W  = PASSES * STEP_BITS;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);

    // Digit store, least significant digit at index zero
    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic [DIV_W-1:0]   div_reg,  div_next;
    logic [DIGIT_W-1:0] rem_reg,  rem_next;
    logic [PASS_W-1:0]  pass_reg, pass_next;
    logic [CNT_W-1:0]   ndig_reg, ndig_next;
    logic [CNT_W-1:0]   pad_reg,  pad_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   k_reg,    k_next;
    logic [BASE_W-1:0]  radix_reg, radix_next;
    logic [DIGIT_W-1:0] fdig_reg, fdig_next;
    logic               sign_reg, sign_next;
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  m_char_reg,  m_char_next;
    logic               m_last_reg,  m_last_next;

    // Input decode
    logic [63:0]           num_ext;
    logic [VALUE_BITS-1:0] raw;
    logic                  negative;
    logic                  is_dec;
    logic [BASE_W-1:0]     radix_sat;
    logic [VALUE_BITS-1:0] magnitude;

    // Divide unit
    logic [DIV_W-1:0]   div_c;
    logic [DIGIT_W-1:0] rem_c;
    logic [BASE_W-1:0]  trial;
    logic               qbit;
    logic               pass_last;
    logic [CNT_W-1:0]   k_m1;
    logic               out_free;

    always_comb begin
        num_ext  = {{32{s_number[NUMBER_W-1]}}, s_number};
        raw      = num_ext[VALUE_BITS-1:0];
        negative = raw[VALUE_BITS-1];
        if (s_base < RADIX_MIN) begin
            radix_sat = RADIX_MIN;
        end else if (s_base > RADIX_MAX) begin
            radix_sat = RADIX_MAX;
        end else begin
            radix_sat = s_base;
        end
        is_dec    = (radix_sat == DECIMAL_BASE);
        magnitude = (negative && is_dec) ? (~raw + VALUE_BITS'(1)) : raw;
    end

    // Eight restoring steps on a remainder below sixteen
    always_comb begin
        rem_c = rem_reg;
        div_c = div_reg;
        trial = '0;
        qbit  = 1'b0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_c, div_c[DIV_W-1]};
            if (trial >= radix_reg) begin
                rem_c = DIGIT_W'(trial - radix_reg);
                qbit  = 1'b1;
            end else begin
                rem_c = trial[DIGIT_W-1:0];
                qbit  = 1'b0;
            end
            div_c = {div_c[DIV_W-2:0], qbit};
        end
    end

    assign pass_last = (pass_reg == PASS_W'(PASSES - 1));
    assign k_m1      = k_reg - CNT_W'(1);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        div_next     = div_reg;
        rem_next     = rem_reg;
        pass_next    = pass_reg;
        ndig_next    = ndig_reg;
        pad_next     = pad_reg;
        fill_next    = fill_reg;
        k_next       = k_reg;
        radix_next   = radix_reg;
        fdig_next    = fdig_reg;
        sign_next    = sign_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (cmd.load) begin
            div_next                   = '0;
            div_next[VALUE_BITS-1:0]   = magnitude;
            rem_next                   = '0;
            pass_next                  = '0;
            ndig_next                  = '0;
            radix_next                 = radix_sat;
            sign_next                  = negative && is_dec;
            fdig_next                  = (negative && !is_dec) ?
                                         DIGIT_W'(radix_sat - 5'd1) : '0;
            if ({1'b0, s_min_digits} > 7'(MAX_DIGITS)) begin
                pad_next = CNT_W'(MAX_DIGITS);
            end else begin
                pad_next = CNT_W'(s_min_digits);
            end
        end

        if (cmd.div_step) begin
            div_next = div_c;
            if (pass_last) begin
                // digit complete: restart the remainder for the next one
                rem_next  = '0;
                pass_next = '0;
                ndig_next = ndig_reg + CNT_W'(1);
            end else begin
                rem_next  = rem_c;
                pass_next = pass_reg + PASS_W'(1);
            end
        end

        if (cmd.emit_start) begin
            fill_next = (pad_reg > ndig_reg) ? (pad_reg - ndig_reg) : '0;
            k_next    = ndig_reg;
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b0;
            unique case (cmd.out_sel)
                OSEL_SIGN: begin
                    m_char_next = CHAR_MINUS;
                end
                OSEL_FILL: begin
                    m_char_next = ascii_of(fdig_reg);
                    fill_next   = fill_reg - CNT_W'(1);
                end
                OSEL_DIGIT: begin
                    m_char_next = ascii_of(rd_data_reg);
                    m_last_next = (k_reg == CNT_W'(1));
                    k_next      = k_m1;
                end
                default: begin
                    m_char_next = CHAR_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_step && pass_last) begin
            digit_mem[ndig_reg[ADDR_W-1:0]] <= rem_c;
        end
        rd_data_reg <= digit_mem[k_m1[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        pass_reg   <= pass_next;
        ndig_reg   <= ndig_next;
        pad_reg    <= pad_next;
        fill_reg   <= fill_next;
        k_reg      <= k_next;
        radix_reg  <= radix_next;
        fdig_reg   <= fdig_next;
        sign_reg   <= sign_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_char_reg;
    assign m_last_char = m_last_reg;

    assign stat.conv_last  = pass_last &&
                             ((div_c == '0) || (ndig_reg == CNT_W'(MAX_DIGITS - 1)));
    assign stat.sign_first = sign_reg;
    assign stat.fill_none  = (fill_reg == '0);
    assign stat.k_one      = (k_reg == CNT_W'(1));
    assign stat.out_free   = out_free;

endmodule

>>> rtl/integer_to_ascii_radix_unit.sv
// Top level of the integer-to-ASCII radix converter.
// Depends on i2a_pkg, i2a_ctrl and i2a_dp.
//
//  channel | direction | ports                                   | meaning
//  --------+-----------+-----------------------------------------+---------------------------
//  s_      | in        | s_valid s_ready s_number s_base          | one value to convert
//          |           | s_min_digits                            |
//  m_      | out       | m_valid m_ready m_out_char m_last_char   | one ASCII character
//
// Operation: the divide unit resolves 8 quotient bits a cycle, in ceil(VALUE_BITS/8) passes per digit;
//   the sequencer then runs a start step and emits the sign if any, the pad characters and,
//   after a store read for each, the digits, most significant first.
// Reset: aresetn (synchronous, active low) idles the sequencer and empties the output register.
// Stalls: a stalled m_ready holds the sequencer at its output register; the next s_ transfer
//   is taken the cycle after the last digit of an item is loaded there.
module integer_to_ascii_radix_unit #(
    parameter int MAX_DIGITS = i2a_pkg::DEF_MAX_DIGITS,
    parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [i2a_pkg::NUMBER_W-1:0] s_number,
    input  logic        [i2a_pkg::BASE_W-1:0]   s_base,
    input  logic        [i2a_pkg::PAD_W-1:0]    s_min_digits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [i2a_pkg::CHAR_W-1:0]   m_out_char,
    output logic                                m_last_char
);
    import i2a_pkg::*;

    i2a_cmd_t  cmd;
    i2a_stat_t stat;

    // Sequencer: accept, divide passes, then sign, pad and digit characters
    i2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Divide unit, digit store and output register
    i2a_dp #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_number     (s_number),
        .s_base       (s_base),
        .s_min_digits (s_min_digits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last_char  (m_last_char),
        .cmd          (cmd),
        .stat         (stat)
    );

`ifndef SYNTHESIS
    // after a transfer in, the block is busy converting
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a transfer");

    // never overwrite a character that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while stalled");

    // loading a new item never coincides with a divide step or with emitting a character
    a_load_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.out_load && !cmd.div_step)
        else $error("load overlaps conversion or emission");
`endif

endmodule
